// ----- rtl/tba_pkg.sv -----
package tba_pkg;

    localparam int GRID_SIZE   = 256;
    localparam int SQRT_STAGES = 30;
    localparam int DIV_STAGES  = 17;
    localparam int COS_STAGES  = 6;
    localparam int LATENCY     = 3 + SQRT_STAGES + DIV_STAGES + COS_STAGES + 2;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [16:0] COS_COEF [4] = '{17'd60, 17'd1367, 17'd16625, 17'd80852};

    localparam logic       SHAPE_CIRCLE = 1'b0;
    localparam logic [1:0] TGT_HEIGHT   = 2'd0;

    typedef enum logic [2:0] {
        REG_SHAPE,
        REG_TARGET,
        REG_BRUSH_X,
        REG_BRUSH_Z,
        REG_RANGE,
        REG_STEP,
        REG_MIN_H,
        REG_MAX_H
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]         vertex_col;
        logic [7:0]         vertex_row;
        logic signed [15:0] current_value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] new_value;
        logic               touched;
    } out_item_t;

    // control that travels alongside the datapath
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               circ;
        logic               zero_rng;
        logic signed [15:0] cur;
    } side_t;

endpackage

// ----- rtl/tba_sqrt.sv -----
module tba_sqrt
    import tba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  side_t       in_side,
    input  logic [27:0] in_n,
    output side_t       out_side,
    output logic [29:0] out_root
);

    side_t       side_reg [SQRT_STAGES];
    logic [31:0] rem_reg  [SQRT_STAGES];
    logic [29:0] root_reg [SQRT_STAGES];
    logic [59:0] rad_reg  [SQRT_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQRT_STAGES; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= in_side;
            for (int i = 1; i < SQRT_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // one root bit per stage, two radicand bits shifted in
    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_stage
        logic [31:0] rem_in;
        logic [29:0] root_in;
        logic [59:0] rad_in;
        logic [33:0] rem_sh;
        logic [33:0] trial;
        logic        ge;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = {in_n, 32'd0};
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
        end

        assign rem_sh = {rem_in, rad_in[59:58]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= ge ? 32'(rem_sh - trial) : rem_sh[31:0];
            root_reg[i] <= {root_in[28:0], ge};
            rad_reg[i]  <= {rad_in[57:0], 2'b00};
        end
    end

    assign out_side = side_reg[SQRT_STAGES-1];
    assign out_root = root_reg[SQRT_STAGES-1];

endmodule

// ----- rtl/tba_div.sv -----
module tba_div
    import tba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  side_t       in_side,
    input  logic [29:0] in_s,
    input  logic [13:0] rng,
    output side_t       out_side,
    output logic [16:0] out_quo
);

    side_t       side_reg [DIV_STAGES];
    logic [13:0] rem_reg  [DIV_STAGES];
    logic [16:0] q_reg    [DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= in_side;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // restoring division, dividend bits leave the top of q as quotient bits enter
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        logic [13:0] rem_in;
        logic [16:0] q_in;
        logic [14:0] rem_sh;
        logic        ge;

        if (i == 0)
        begin : g_first
            assign rem_in = {1'b0, in_s[29:17]};
            assign q_in   = in_s[16:0];
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign q_in   = q_reg[i-1];
        end

        assign rem_sh = {rem_in, q_in[16]};
        assign ge     = (rem_sh >= {1'b0, rng});

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= ge ? 14'(rem_sh - {1'b0, rng}) : rem_sh[13:0];
            q_reg[i]   <= {q_in[15:0], ge};
        end
    end

    assign out_side = side_reg[DIV_STAGES-1];
    assign out_quo  = q_reg[DIV_STAGES-1];

endmodule

// ----- rtl/tba_cos.sv -----
module tba_cos
    import tba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  side_t       in_side,
    input  logic [16:0] in_t,
    output side_t       out_side,
    output logic [16:0] out_w
);

    side_t       side_reg [COS_STAGES];
    logic [16:0] u_reg    [4];
    logic [17:0] m_reg    [4];
    logic [16:0] w_reg;
    logic [16:0] t_cap;
    logic [33:0] t_sq;
    logic signed [18:0] w_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COS_STAGES; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= in_side;
            for (int i = 1; i < COS_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign t_cap = (in_t > ONE_Q16) ? ONE_Q16 : in_t;
    assign t_sq  = {17'd0, t_cap} * {17'd0, t_cap};

    always_ff @(posedge clk)
    begin
        u_reg[0] <= t_sq[32:16];
    end

    // Horner steps on u, one product per stage
    for (genvar k = 0; k < 4; k++)
    begin : g_horner
        logic [16:0] p;
        logic [33:0] prod;

        if (k == 0)
        begin : g_first
            assign p = COS_COEF[0];
        end
        else
        begin : g_next
            assign p = 17'(COS_COEF[k] - m_reg[k-1][16:0]);
        end

        assign prod = {17'd0, p} * {17'd0, u_reg[k]};

        always_ff @(posedge clk)
        begin
            m_reg[k] <= prod[33:16];
        end

        if (k < 3)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                u_reg[k+1] <= u_reg[k];
            end
        end
    end

    assign w_full = 19'sh10000 - $signed({1'b0, m_reg[3]});

    always_ff @(posedge clk)
    begin
        if (w_full < 19'sd0)
        begin
            w_reg <= '0;
        end
        else if (w_full > 19'sh10000)
        begin
            w_reg <= ONE_Q16;
        end
        else
        begin
            w_reg <= w_full[16:0];
        end
    end

    assign out_side = side_reg[COS_STAGES-1];
    assign out_w    = w_reg;

endmodule

// ----- rtl/terrain_brush_apply.sv -----
// Terrain brush: applies one stroke of the configured brush to one grid vertex.
// Input channel: drive vertex with start high; busy stays low, so an item is
// taken at every edge that start is high, one vertex per clock sustained.
// Output channel: done pulses for one cycle with result (new_value, touched);
// results leave in input order. The receiver cannot stall, so there is no hold.
// Pipeline, from the accept edge to the edge that takes the result:
// 3 stages of distance and radius compare, 30 stages of square root (one root
// bit each), 17 stages of division by the range (one quotient bit each),
// 6 stages of cosine polynomial and 2 of scaling, add and clamp.
// Configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready is always
// high. Write only while no items are in flight; the brush settings are read
// along the pipeline.
// Reset (rst_n low, asynchronous) clears all in-flight items and loads the
// default brush: circle, height target, center 0, range 10.0, no step,
// height limits -20.0 and +20.0.
module terrain_brush_apply
    import tba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    vertex,
    output logic        done,
    output out_item_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [15:0] cfg_data
);

    logic               shape_reg;
    logic [1:0]         target_reg;
    logic [13:0]        bx_reg;
    logic [13:0]        bz_reg;
    logic [13:0]        range_reg;
    logic signed [15:0] step_reg;
    logic signed [15:0] minh_reg;
    logic signed [15:0] maxh_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg  <= SHAPE_CIRCLE;
            target_reg <= TGT_HEIGHT;
            bx_reg     <= '0;
            bz_reg     <= '0;
            range_reg  <= 14'd640;
            step_reg   <= '0;
            minh_reg   <= -16'sd5120;
            maxh_reg   <= 16'sd5120;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SHAPE:   shape_reg  <= cfg_data[0];
                REG_TARGET:  target_reg <= cfg_data[1:0];
                REG_BRUSH_X: bx_reg     <= cfg_data[13:0];
                REG_BRUSH_Z: bz_reg     <= cfg_data[13:0];
                REG_RANGE:   range_reg  <= cfg_data[13:0];
                REG_STEP:    step_reg   <= $signed(cfg_data);
                REG_MIN_H:   minh_reg   <= $signed(cfg_data);
                REG_MAX_H:   maxh_reg   <= $signed(cfg_data);
                default:     shape_reg  <= shape_reg;
            endcase
        end
    end

    // ---------------- stage 1: offsets and square box test
    logic signed [14:0] dx;
    logic signed [14:0] dz;
    logic               on_grid;
    logic signed [15:0] box_l;
    logic signed [15:0] box_b;
    logic [16:0]        box_r;
    logic [16:0]        box_t;
    logic [9:0]         li;
    logic [9:0]         ri;
    logic [9:0]         bi;
    logic [9:0]         ti;
    logic               sq_in;
    side_t              side_in;

    assign dx = $signed({1'b0, vertex.vertex_col, 6'd0}) - $signed({1'b0, bx_reg});
    assign dz = $signed({1'b0, vertex.vertex_row, 6'd0}) - $signed({1'b0, bz_reg});
    assign on_grid = (32'(vertex.vertex_col) < GRID_SIZE) &&
                     (32'(vertex.vertex_row) < GRID_SIZE);

    assign box_l = $signed({1'b0, bx_reg, 1'b0}) - $signed({2'b00, range_reg});
    assign box_b = $signed({1'b0, bz_reg, 1'b0}) - $signed({2'b00, range_reg});
    assign box_r = {2'b00, bx_reg, 1'b0} + {3'b000, range_reg};
    assign box_t = {2'b00, bz_reg, 1'b0} + {3'b000, range_reg};
    assign li = box_l[15] ? 10'd0 : {1'b0, box_l[15:7]};
    assign bi = box_b[15] ? 10'd0 : {1'b0, box_b[15:7]};
    assign ri = box_r[16:7];
    assign ti = box_t[16:7];
    assign sq_in = ({2'b00, vertex.vertex_col} >= li) && ({2'b00, vertex.vertex_col} <= ri) &&
                   ({2'b00, vertex.vertex_row} >= bi) && ({2'b00, vertex.vertex_row} <= ti);

    always_comb
    begin
        side_in.valid    = start && !busy;
        side_in.circ     = (shape_reg == SHAPE_CIRCLE);
        side_in.hit      = on_grid && ((shape_reg == SHAPE_CIRCLE) || sq_in);
        side_in.zero_rng = (range_reg == 14'd0);
        side_in.cur      = vertex.current_value;
    end

    side_t       s1_side_reg;
    logic [13:0] adx_reg;
    logic [13:0] adz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg <= '0;
        end
        else
        begin
            s1_side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        adx_reg <= dx[14] ? 14'(-dx) : dx[13:0];
        adz_reg <= dz[14] ? 14'(-dz) : dz[13:0];
    end

    // ---------------- stage 2: squares
    side_t       s2_side_reg;
    logic [27:0] sqx_reg;
    logic [27:0] sqz_reg;
    logic [27:0] r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_side_reg <= '0;
        end
        else
        begin
            s2_side_reg <= s1_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= adx_reg * adx_reg;
        sqz_reg <= adz_reg * adz_reg;
        r2_reg  <= range_reg * range_reg;
    end

    // ---------------- stage 3: radius compare
    logic [28:0] d2;
    side_t       s3_side_next;
    side_t       s3_side_reg;
    logic [27:0] d2_reg;

    assign d2 = {1'b0, sqx_reg} + {1'b0, sqz_reg};

    always_comb
    begin
        s3_side_next = s2_side_reg;
        if (s2_side_reg.circ)
        begin
            s3_side_next.hit = s2_side_reg.hit && (d2 <= {1'b0, r2_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_side_reg <= '0;
        end
        else
        begin
            s3_side_reg <= s3_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d2_reg <= d2[27:0];
    end

    // ---------------- distance ratio and falloff
    side_t       sq_side;
    logic [29:0] sq_root;
    side_t       dv_side;
    logic [16:0] dv_quo;
    side_t       cs_side;
    logic [16:0] cs_w;

    tba_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_side  (s3_side_reg),
        .in_n     (d2_reg),
        .out_side (sq_side),
        .out_root (sq_root)
    );

    tba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_side  (sq_side),
        .in_s     (sq_root),
        .rng      (range_reg),
        .out_side (dv_side),
        .out_quo  (dv_quo)
    );

    tba_cos u_cos (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_side  (dv_side),
        .in_t     (dv_quo),
        .out_side (cs_side),
        .out_w    (cs_w)
    );

    // ---------------- scale step by weight
    logic [16:0] weight;
    logic [15:0] mag;
    side_t       fin_side_reg;
    logic [32:0] prod_reg;

    assign weight = cs_side.zero_rng ? ONE_Q16 : cs_w;
    assign mag    = step_reg[15] ? 16'(-step_reg) : step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_side_reg <= '0;
        end
        else
        begin
            fin_side_reg <= cs_side;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= {17'd0, mag} * {16'd0, weight};
    end

    // ---------------- round, add, clamp
    logic [16:0]        rnd;
    logic signed [17:0] inc;
    logic signed [17:0] sum;
    logic signed [17:0] clamped;
    logic signed [17:0] lo_lim;
    logic signed [17:0] hi_lim;
    out_item_t          result_next;
    out_item_t          result_reg;
    logic               done_reg;

    assign rnd = 17'((prod_reg + 33'd32768) >> 16);

    always_comb
    begin
        if (!fin_side_reg.circ)
        begin
            inc = 18'(step_reg);
        end
        else if (step_reg[15])
        begin
            inc = -$signed({1'b0, rnd});
        end
        else
        begin
            inc = $signed({1'b0, rnd});
        end

        sum = 18'($signed(fin_side_reg.cur)) + inc;

        if (target_reg == TGT_HEIGHT)
        begin
            lo_lim = 18'(minh_reg);
            hi_lim = 18'(maxh_reg);
        end
        else
        begin
            lo_lim = 18'sd0;
            hi_lim = 18'sd256;
        end

        clamped = (sum < lo_lim) ? lo_lim : sum;
        clamped = (clamped > hi_lim) ? hi_lim : clamped;

        result_next.touched   = fin_side_reg.hit;
        result_next.new_value = fin_side_reg.hit ? clamped[15:0] : fin_side_reg.cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_side_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("item did not complete at the expected latency");

    a_weight_range : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.touched && $past(target_reg) != TGT_HEIGHT |->
            $signed(result.new_value) >= 16'sd0 && $signed(result.new_value) <= 16'sd256)
        else $error("blend weight left its range");

    a_untouched_pass : assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.touched |-> result.new_value == $past(fin_side_reg.cur))
        else $error("untouched vertex value changed");
`endif

endmodule

// ----- sim/tb_terrain_brush_apply.sv -----
`timescale 1ns / 1ps

module tb_terrain_brush_apply;
    import tba_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    vertex;
    logic        done;
    out_item_t   result;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [15:0] cfg_data;

    // local copy of the brush settings
    logic               shape_q;
    logic [1:0]         target_q;
    logic [13:0]        bx_q;
    logic [13:0]        bz_q;
    logic [13:0]        range_q;
    logic signed [15:0] step_q;
    logic signed [15:0] hmin_q;
    logic signed [15:0] hmax_q;

    out_item_t stroke_q[$];
    int        fail_cnt = 0;
    longint    cycle_cnt;

    terrain_brush_apply i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .vertex    (vertex),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint falloff_weight(longint t);
        longint u;
        longint p;
        longint w;
        u = (t * t) >>> 16;
        p = 60;
        p = 1367 - ((p * u) >>> 16);
        p = 16625 - ((p * u) >>> 16);
        p = 80852 - ((p * u) >>> 16);
        w = 65536 - ((p * u) >>> 16);
        if (w < 0)
            w = 0;
        if (w > 65536)
            w = 65536;
        return w;
    endfunction

    function automatic out_item_t brush_stroke(in_item_t v);
        out_item_t o;
        longint dx, dz, d2, r2, t, w, mag, r, inc, val, lo, hi, lb, bb;
        logic hit;
        hit = 1'b0;
        inc = 0;
        if (shape_q == SHAPE_CIRCLE)
        begin
            dx = longint'(v.vertex_col) * 64 - longint'(bx_q);
            dz = longint'(v.vertex_row) * 64 - longint'(bz_q);
            d2 = dx * dx + dz * dz;
            r2 = longint'(range_q) * longint'(range_q);
            if (d2 <= r2)
            begin
                hit = 1'b1;
                if (range_q == 0)
                    w = 65536;
                else
                begin
                    t = longint'(floor_sqrt(longint'(d2) << 32)) / longint'(range_q);
                    if (t > 65536)
                        t = 65536;
                    w = falloff_weight(t);
                end
                mag = (step_q < 0) ? -longint'(step_q) : longint'(step_q);
                r   = (mag * w + 32768) >>> 16;
                inc = (step_q < 0) ? -r : r;
            end
        end
        else
        begin
            lb = 2 * longint'(bx_q) - longint'(range_q);
            bb = 2 * longint'(bz_q) - longint'(range_q);
            if (lb < 0)
                lb = 0;
            if (bb < 0)
                bb = 0;
            lo = lb >>> 7;
            hi = (2 * longint'(bx_q) + longint'(range_q)) >>> 7;
            if (v.vertex_col >= lo && v.vertex_col <= hi
                && v.vertex_row >= (bb >>> 7)
                && v.vertex_row <= ((2 * longint'(bz_q) + longint'(range_q)) >>> 7))
            begin
                hit = 1'b1;
                inc = step_q;
            end
        end
        val = v.current_value;
        if (hit)
        begin
            val = val + inc;
            if (target_q == TGT_HEIGHT)
            begin
                if (val < hmin_q)
                    val = hmin_q;
                if (val > hmax_q)
                    val = hmax_q;
            end
            else
            begin
                if (val < 0)
                    val = 0;
                if (val > 256)
                    val = 256;
            end
        end
        o.new_value = val[15:0];
        o.touched   = hit;
        return o;
    endfunction

    always @(posedge clk)
    begin
        out_item_t exp_item;
        if (rst_n && done)
        begin
            if (stroke_q.size() == 0)
            begin
                $error("unexpected item: new_value %0d touched %0b",
                       result.new_value, result.touched);
                fail_cnt++;
            end
            else
            begin
                exp_item = stroke_q.pop_front();
                if (result.new_value !== exp_item.new_value)
                begin
                    $error("new_value expected %0d actual %0d",
                           exp_item.new_value, result.new_value);
                    fail_cnt++;
                end
                if (result.touched !== exp_item.touched)
                begin
                    $error("touched expected %0b actual %0b",
                           exp_item.touched, result.touched);
                    fail_cnt++;
                end
            end
        end
    end

    function automatic int gap_len();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50)
            n = 0;
        else if (n < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        return n;
    endfunction

    task automatic send_vertex(in_item_t v, bit gaps);
        int n;
        start  <= 1'b1;
        vertex <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        stroke_q = {stroke_q, brush_stroke(v)};
        if (gaps && ($urandom_range(0, 3) != 0))
        begin
            n = gap_len();
            if (n > 0)
            begin
                start <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (stroke_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_SHAPE:   shape_q  = data[0];
            REG_TARGET:  target_q = data[1:0];
            REG_BRUSH_X: bx_q     = data[13:0];
            REG_BRUSH_Z: bz_q     = data[13:0];
            REG_RANGE:   range_q  = data[13:0];
            REG_STEP:    step_q   = data;
            REG_MIN_H:   hmin_q   = data;
            REG_MAX_H:   hmax_q   = data;
            default: ;
        endcase
    endtask

    task automatic set_brush(logic shp, logic [1:0] tgt, logic [13:0] x, logic [13:0] z,
                             logic [13:0] rng, logic [15:0] stp);
        write_reg(REG_SHAPE, {15'd0, shp});
        write_reg(REG_TARGET, {14'd0, tgt});
        write_reg(REG_BRUSH_X, {2'd0, x});
        write_reg(REG_BRUSH_Z, {2'd0, z});
        write_reg(REG_RANGE, {2'd0, rng});
        write_reg(REG_STEP, stp);
    endtask

    function automatic in_item_t mk_vertex(int col, int row, int val);
        in_item_t v;
        v.vertex_col    = col[7:0];
        v.vertex_row    = row[7:0];
        v.current_value = val[15:0];
        return v;
    endfunction

    // vertex near the brush center, random value
    function automatic in_item_t near_vertex(int spread);
        int c, r;
        c = int'(bx_q >> 6) + $urandom_range(0, 2 * spread) - spread;
        r = int'(bz_q >> 6) + $urandom_range(0, 2 * spread) - spread;
        if (c < 0) c = 0;
        if (c > 255) c = 255;
        if (r < 0) r = 0;
        if (r > 255) r = 255;
        return mk_vertex(c, r, $urandom());
    endfunction

    task automatic test_reset_brush();
        send_vertex(mk_vertex(0, 0, 100), 1'b0);
        send_vertex(mk_vertex(5, 5, -32768), 1'b0);
        send_vertex(mk_vertex(255, 255, 32767), 1'b0);
        drain();
    endtask

    task automatic test_circle_directed();
        set_brush(1'b0, 2'd0, 14'd640, 14'd640, 14'd640, 16'sd2560);
        write_reg(REG_MIN_H, 16'h8000);
        write_reg(REG_MAX_H, 16'h7FFF);
        send_vertex(mk_vertex(10, 10, 0), 1'b0);
        send_vertex(mk_vertex(20, 10, 0), 1'b0);
        send_vertex(mk_vertex(21, 10, 0), 1'b0);
        send_vertex(mk_vertex(17, 17, 32767), 1'b0);
        send_vertex(mk_vertex(13, 14, -32768), 1'b0);
        drain();
        // zero range: only the exact center is touched
        write_reg(REG_RANGE, 16'd0);
        write_reg(REG_STEP, 16'h8000);
        send_vertex(mk_vertex(10, 10, -100), 1'b0);
        send_vertex(mk_vertex(11, 10, 50), 1'b0);
        drain();
        // crossed height limits
        set_brush(1'b0, 2'd0, 14'h3FFF, 14'h3FFF, 14'h3FFF, 16'h7FFF);
        write_reg(REG_MIN_H, 16'sd300);
        write_reg(REG_MAX_H, -16'sd300);
        send_vertex(mk_vertex(255, 255, 0), 1'b0);
        send_vertex(mk_vertex(0, 0, 0), 1'b0);
        send_vertex(mk_vertex(200, 40, 1000), 1'b0);
        drain();
    endtask

    task automatic test_square_and_weights();
        set_brush(1'b1, 2'd1, 14'd100, 14'd0, 14'd200, 16'sd128);
        send_vertex(mk_vertex(0, 0, 200), 1'b0);
        send_vertex(mk_vertex(2, 1, -5), 1'b0);
        send_vertex(mk_vertex(3, 0, 0), 1'b0);
        drain();
        set_brush(1'b1, 2'd3, 14'h3FFF, 14'h3FFF, 14'd0, 16'h8000);
        send_vertex(mk_vertex(255, 255, 100), 1'b0);
        send_vertex(mk_vertex(254, 255, 100), 1'b0);
        drain();
        write_reg(REG_TARGET, 16'd2);
    endtask

    task automatic random_phase(int n_items);
        logic [15:0] lo, hi;
        lo = $urandom();
        hi = $urandom();
        write_reg(REG_MIN_H, ($urandom_range(0, 3) == 0) ? hi : 16'h8000 | lo[14:0]);
        write_reg(REG_MAX_H, ($urandom_range(0, 3) == 0) ? lo : {1'b0, hi[14:0]});
        set_brush(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                  ($urandom_range(0, 7) == 0) ? 14'($urandom_range(0, 16383))
                                              : 14'($urandom_range(0, 1200)),
                  16'($urandom()));
        if ($urandom_range(0, 4) == 0)
            write_reg(REG_BRUSH_X, 16'($urandom_range(0, 255) << 6));
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_vertex(mk_vertex($urandom_range(0, 255), $urandom_range(0, 255),
                                      $urandom()), 1'b1);
            else
                send_vertex(near_vertex(int'(range_q >> 6) + 2), 1'b1);
        end
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        vertex    = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_SHAPE;
        cfg_data  = '0;
        shape_q   = 1'b0;
        target_q  = 2'd0;
        bx_q      = '0;
        bz_q      = '0;
        range_q   = 14'd640;
        step_q    = '0;
        hmin_q    = -16'sd5120;
        hmax_q    = 16'sd5120;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_brush();
        test_circle_directed();
        test_square_and_weights();
        for (int ph = 0; ph < 20; ph++)
            random_phase(34);

        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
